FILE: hdl/sle_pkg.sv
// Shared types and constants for the serial line editor.
// Used by every module under hdl/.
package sle_pkg;

  // Input commands
  localparam logic [1:0] CMD_RX   = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_TX   = 2'd2;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Entries in the queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_NOLINE  = 2'd2,
    KIND_OVERRUN = 2'd3
  } kind_e;

  // How the back end expands one job into result words
  typedef enum logic [1:0] {
    OP_SINGLE  = 2'd0,  // one word
    OP_CR_THEN = 2'd1,  // CR, then the value
    OP_ERASE   = 2'd2   // BS, space, BS
  } job_op_e;

  typedef struct packed {
    job_op_e    op;
    kind_e      kind;
    logic [7:0] value;
  } job_t;

endpackage

FILE: hdl/sle_in_if.sv
// Input channel of the serial line editor: valid/ready with command and data byte.
// Depends on nothing but the port widths.
interface sle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

FILE: hdl/sle_out_if.sv
// Output channel of the serial line editor: valid/ready with kind, value and last.
// Depends on nothing but the port widths.
interface sle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, kind, value, last, input ready);
  modport sink   (input valid, kind, value, last, output ready);
endinterface

FILE: hdl/sle_front.sv
// Front end: accepts input words, edits the line store and emits a job where one is due.
// Depends on sle_pkg and sle_in_if.
module sle_front #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sle_in_if.sink        in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output sle_pkg::job_t push_job_o
);
  import sle_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam logic [AW-1:0] FULL = AW'(LINE_DEPTH - 1);

  logic [7:0]    mem [LINE_DEPTH];
  logic [7:0]    rd_q;

  logic [AW-1:0] fill_q, fill_d;
  logic [AW-1:0] ridx_q, ridx_d;
  logic          pend_q, pend_d;

  logic          s1_v_q, s1_v_d;
  job_t          s1_job_q;
  logic          s1_mem_q;

  logic          accept;
  logic          has_job;
  job_t          job;
  logic          from_mem;
  logic          mem_we, mem_re;
  logic [7:0]    wdata;
  logic [7:0]    ch;

  assign in_i.ready = !s1_v_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // CR is taken as LF
  assign ch = (in_i.data_byte == CH_CR) ? CH_LF : in_i.data_byte;

  always_comb begin
    has_job    = 1'b0;
    job.op     = OP_SINGLE;
    job.kind   = KIND_TX;
    job.value  = '0;
    from_mem   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    wdata      = ch;
    fill_d     = fill_q;
    ridx_d     = ridx_q;
    pend_d     = pend_q;
    unique case (in_i.command)
      CMD_RX: begin
        if (pend_q) begin
          has_job  = 1'b1;
          job.kind = KIND_OVERRUN;
        end else if (ch == CH_LF) begin
          has_job   = 1'b1;
          job.op    = OP_CR_THEN;
          job.value = CH_LF;
          mem_we    = 1'b1;
          pend_d    = 1'b1;
          ridx_d    = '0;
        end else if (ch >= CH_SPACE && ch <= CH_TILDE) begin
          has_job = 1'b1;
          if (fill_q == FULL) begin
            job.value = CH_BEL;
          end else begin
            job.value = ch;
            mem_we    = 1'b1;
            fill_d    = fill_q + AW'(1);
          end
        end else if (ch == CH_BS || ch == CH_DEL) begin
          if (fill_q != '0) begin
            has_job = 1'b1;
            job.op  = OP_ERASE;
            fill_d  = fill_q - AW'(1);
          end
        end
      end
      CMD_READ: begin
        has_job = 1'b1;
        if (!pend_q) begin
          job.kind = KIND_NOLINE;
        end else begin
          job.kind = KIND_DELIVER;
          from_mem = 1'b1;
          mem_re   = 1'b1;
          // LF sits at the fill position: delivering it frees the line
          if (ridx_q == fill_q) begin
            pend_d = 1'b0;
            fill_d = '0;
            ridx_d = '0;
          end else begin
            ridx_d = ridx_q + AW'(1);
          end
        end
      end
      CMD_TX: begin
        has_job   = 1'b1;
        job.op    = (in_i.data_byte == CH_LF) ? OP_CR_THEN : OP_SINGLE;
        job.value = in_i.data_byte;
      end
      default: begin
        has_job = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      mem[fill_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && mem_re) begin
      rd_q <= mem[ridx_q];
    end
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = has_job;
    end else if (push_ready_i) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ridx_q <= '0;
      pend_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      if (accept) begin
        fill_q <= fill_d;
        ridx_q <= ridx_d;
        pend_q <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_job_q <= job;
      s1_mem_q <= from_mem;
    end
  end

  always_comb begin
    push_job_o = s1_job_q;
    if (s1_mem_q) begin
      push_job_o.value = rd_q;
    end
  end

  assign push_valid_o = s1_v_q;

endmodule

FILE: hdl/sle_queue.sv
// Short job queue between the front and back ends of the serial line editor.
// Depends on sle_pkg.
module sle_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  sle_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output sle_pkg::job_t pop_job_o
);
  import sle_pkg::*;

  job_t           entry_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;
  logic           push, pop;

  assign push_ready_o = (cnt_q != (QAW+1)'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + QAW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + QAW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

endmodule

FILE: hdl/sle_back.sv
// Back end: expands each queued job into result words and drives the output register.
// Depends on sle_pkg and sle_out_if.
module sle_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  sle_pkg::job_t pop_job_i,
  sle_out_if.source     out_o
);
  import sle_pkg::*;

  logic [1:0] step_q;
  logic       ov_q;
  logic [1:0] kind_q;
  logic [7:0] value_q;
  logic       last_q;

  logic       load, take;
  logic [7:0] res_value;
  logic       res_last;

  always_comb begin
    res_value = pop_job_i.value;
    res_last  = 1'b1;
    unique case (pop_job_i.op)
      OP_SINGLE: begin
        res_last = 1'b1;
      end
      OP_CR_THEN: begin
        if (step_q == 2'd0) begin
          res_value = CH_CR;
          res_last  = 1'b0;
        end
      end
      OP_ERASE: begin
        res_value = (step_q == 2'd1) ? CH_SPACE : CH_BS;
        res_last  = (step_q == 2'd2);
      end
      default: begin
        res_last = 1'b1;
      end
    endcase
  end

  // Output register frees up when empty or when the word is taken
  assign load        = !ov_q || out_o.ready;
  assign take        = load && pop_valid_i;
  assign pop_ready_o = take && res_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      step_q <= '0;
    end else begin
      if (load) begin
        ov_q <= pop_valid_i;
      end
      if (take) begin
        step_q <= res_last ? 2'd0 : step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q  <= pop_job_i.kind;
      value_q <= res_value;
      last_q  <= res_last;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.kind  = kind_q;
  assign out_o.value = value_q;
  assign out_o.last  = last_q;

endmodule

FILE: hdl/serial_line_editor.sv
// Serial line editor: one input word per cycle goes into the front end when it is ready; it
// edits the line store and queues a job. The back end emits one result word per cycle while
// the output is ready; a job yields one to three result words, with up to four jobs waiting
// between the sides. Each job passes the front stage, the queue and the output register.
// Depends on sle_pkg, sle_in_if, sle_out_if, sle_front, sle_queue and sle_back.
module serial_line_editor #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sle_in_if.sink     in_i,
  sle_out_if.source  out_o
);
  import sle_pkg::*;

  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  sle_front #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  sle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  sle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_o       (out_o)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for serial_line_editor: drives command words with random gaps and ready stalls,
// predicts echo, delivery and status words with its own line model, checks each output word.
// Depends on sle_pkg, sle_in_if, sle_out_if and the serial_line_editor RTL.
module testbench;
  import sle_pkg::*;

  localparam int unsigned LINE_DEPTH   = 32;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_WORDS = 280;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       last;
  } out_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sle_in_if  in_ch ();
  sle_out_if out_ch ();

  serial_line_editor #(
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #6 clk_i = ~clk_i;

  // Line model state
  logic [7:0]  line_buf [LINE_DEPTH];
  int unsigned fill_cnt;
  int unsigned rd_idx;
  bit          line_ready;

  out_word_t   echo_q [$];
  int unsigned words_sent;
  int unsigned cycle_cnt;
  int unsigned mismatches;
  bit          src_steady;
  bit          sink_steady;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void push_word(kind_e k, logic [7:0] v);
    out_word_t w;
    w.kind  = k;
    w.value = v;
    w.last  = 1'b0;
    echo_q.push_back(w);
  endfunction

  // LF always goes out as CR LF
  function automatic void push_tx(logic [7:0] c);
    if (c == CH_LF) push_word(KIND_TX, CH_CR);
    push_word(KIND_TX, c);
  endfunction

  function automatic void apply_line_edit(logic [1:0] cmd, logic [7:0] b);
    int unsigned first;
    logic [7:0]  c;
    logic [7:0]  v;
    first = echo_q.size();
    c = b;
    case (cmd)
      CMD_RX: begin
        if (line_ready) begin
          push_word(KIND_OVERRUN, 8'h00);
        end else begin
          if (c == CH_CR) c = CH_LF;
          if (c == CH_LF) begin
            if (fill_cnt < LINE_DEPTH) line_buf[fill_cnt] = c;
            push_tx(c);
            line_ready = 1'b1;
            rd_idx = 0;
          end else if (c >= CH_SPACE && c <= CH_TILDE) begin
            // keep one slot free for the LF
            if (fill_cnt >= LINE_DEPTH - 1) begin
              push_tx(CH_BEL);
            end else begin
              line_buf[fill_cnt] = c;
              fill_cnt++;
              push_tx(c);
            end
          end else if ((c == CH_BS || c == CH_DEL) && fill_cnt > 0) begin
            push_tx(CH_BS);
            push_tx(CH_SPACE);
            push_tx(CH_BS);
            fill_cnt--;
          end
        end
      end
      CMD_READ: begin
        if (!line_ready) begin
          push_word(KIND_NOLINE, 8'h00);
        end else begin
          v = (rd_idx < LINE_DEPTH) ? line_buf[rd_idx] : CH_LF;
          rd_idx++;
          if (v == CH_LF || rd_idx > fill_cnt) begin
            line_ready = 1'b0;
            fill_cnt = 0;
            rd_idx = 0;
          end
          push_word(KIND_DELIVER, v);
        end
      end
      CMD_TX: push_tx(c);
      default: ;
    endcase
    if (echo_q.size() > first) echo_q[$].last = 1'b1;
  endfunction

  function automatic logic [7:0] printable_byte();
    return 8'($urandom_range(CH_SPACE, CH_TILDE));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [7:0] b);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    apply_line_edit(cmd, b);
    words_sent++;
  endtask

  function automatic void note_mismatch(string what, out_word_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0s: expected kind %0d value %02h last %0b, got kind %0d value %02h last %0b",
               what, want.kind, want.value, want.last,
               out_ch.kind, out_ch.value, out_ch.last);
  endfunction

  // Output side: stall ready at random, check every word taken
  initial begin : result_check
    out_word_t   want;
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 8);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      if (echo_q.size() == 0) begin
        want = '0;
        note_mismatch("word with none awaited", want);
      end else begin
        want = echo_q.pop_front();
        if (out_ch.kind !== want.kind || out_ch.value !== want.value ||
            out_ch.last !== want.last)
          note_mismatch("word mismatch", want);
      end
    end
  end

  task automatic test_idle_words();
    send_word(CMD_READ, 8'h00);     // no line yet
    send_word(CMD_UNUSED, 8'hFF);   // dropped silently
    send_word(CMD_TX, 8'h00);
    send_word(CMD_TX, 8'hFF);
    send_word(CMD_TX, CH_LF);
    send_word(CMD_TX, CH_CR);
  endtask

  task automatic test_line_editing();
    send_word(CMD_RX, CH_BS);       // erase on empty line
    send_word(CMD_RX, CH_SPACE);
    send_word(CMD_RX, CH_TILDE);
    send_word(CMD_RX, 8'h1F);       // control bytes are ignored
    send_word(CMD_RX, 8'h80);
    send_word(CMD_RX, 8'hFF);
    send_word(CMD_RX, 8'h00);
    send_word(CMD_RX, CH_DEL);
    send_word(CMD_RX, 8'h41);
    send_word(CMD_RX, CH_BS);
    send_word(CMD_RX, 8'h7A);
    send_word(CMD_RX, CH_CR);
    send_word(CMD_RX, 8'h42);       // overrun while pending
    send_word(CMD_RX, CH_LF);
    while (line_ready) send_word(CMD_READ, 8'hFF);
    send_word(CMD_READ, 8'h00);
  endtask

  task automatic test_full_line();
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    repeat (LINE_DEPTH + 1) send_word(CMD_RX, printable_byte());
    send_word(CMD_RX, CH_DEL);
    send_word(CMD_RX, printable_byte());
    send_word(CMD_RX, printable_byte());
    send_word(CMD_RX, CH_LF);
    send_word(CMD_RX, CH_CR);
    while (line_ready) send_word(CMD_READ, any_byte());
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned len;
    int unsigned pick;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        // mostly short lines, now and then one that overflows
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        repeat (len) begin
          pick = $urandom_range(0, 19);
          if (pick < 2) send_word(CMD_RX, pick[0] ? CH_BS : CH_DEL);
          else if (pick == 2) send_word(CMD_RX, any_byte());
          else if (pick == 3) send_word(CMD_TX, any_byte());
          else send_word(CMD_RX, printable_byte());
        end
        send_word(CMD_RX, $urandom_range(0, 1) ? CH_CR : CH_LF);
      end else begin
        repeat ($urandom_range(1, 4)) send_word(2'($urandom_range(0, 3)), any_byte());
      end
      // read the line back, with a stray byte or a transmit in between
      while (line_ready) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) send_word(CMD_RX, any_byte());
        else if (pick == 1) send_word(CMD_TX, any_byte());
        else send_word(CMD_READ, any_byte());
      end
      if ($urandom_range(0, 3) == 0) send_word(CMD_READ, any_byte());
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_RX;
    in_ch.data_byte = 8'h00;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_words();
    test_line_editing();
    test_full_line();
    test_random_traffic();

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && echo_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
